// ===== src/crv_pkg.sv =====
// Shared types, constants and the CRC-32 byte step for the credential record validator.
package crv_pkg;

    // Record geometry and byte position counter.
    localparam int unsigned POS_W = 7;
    localparam logic [POS_W-1:0] POS_MAGIC_END = 7'd4;
    localparam logic [POS_W-1:0] POS_VER_LO    = 7'd4;
    localparam logic [POS_W-1:0] POS_VER_HI    = 7'd5;
    localparam logic [POS_W-1:0] POS_ROLE      = 7'd6;
    localparam logic [POS_W-1:0] POS_ALG       = 7'd7;
    localparam logic [POS_W-1:0] POS_GEN_LO    = 7'd8;
    localparam logic [POS_W-1:0] POS_GEN_END   = 7'd12;
    localparam logic [POS_W-1:0] POS_MINLEN_LO = 7'd12;
    localparam logic [POS_W-1:0] POS_MINLEN_HI = 7'd13;
    localparam logic [POS_W-1:0] CRC_SPAN      = 7'd76;
    localparam logic [POS_W-1:0] RECORD_LAST   = 7'd79;
    localparam logic [POS_W-1:0] RECORD_SIZE   = 7'd80;
    localparam logic [POS_W-1:0] POS_SAT       = 7'd81;

    // CRC-32, reflected form.
    localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;
    localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;

    // Value of an unprogrammed byte.
    localparam logic [7:0] ERASED_BYTE = 8'hFF;

    // Configuration port geometry.
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 32;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MAGIC   = 3'd0,
        CFG_SCHEMA  = 3'd1,
        CFG_ROLE_A  = 3'd2,
        CFG_ROLE_B  = 3'd3,
        CFG_ALG     = 3'd4,
        CFG_MIN_LEN = 3'd5,
        CFG_MAX_LEN = 3'd6
    } t_cfg_idx;

    // Result status codes, in check priority order after OK, except that LENGTH is checked before EMPTY.
    typedef enum logic [3:0] {
        ST_OK     = 4'd0,
        ST_EMPTY  = 4'd1,
        ST_LENGTH = 4'd2,
        ST_MAGIC  = 4'd3,
        ST_SCHEMA = 4'd4,
        ST_ROLE   = 4'd5,
        ST_ALG    = 4'd6,
        ST_POLICY = 4'd7,
        ST_CRC    = 4'd8
    } t_status;

    // Expected values programmed through the configuration port.
    typedef struct packed {
        logic [15:0] schema_version;
        logic [7:0]  role_a;
        logic [7:0]  role_b;
        logic [7:0]  algorithm;
        logic [15:0] min_len;
        logic [15:0] max_len;
    } t_policy;

    // Everything captured from a record, as seen at its final byte.
    typedef struct packed {
        logic        at_end;
        logic        erased;
        logic        magic_mismatch;
        logic [15:0] version;
        logic [7:0]  role;
        logic [7:0]  algorithm;
        logic [15:0] min_len;
        logic [31:0] stored_check;
        logic [31:0] crc;
    } t_record;

    // One byte of reflected CRC-32, unrolled over its eight bits.
    function automatic logic [31:0] crc_byte(input logic [31:0] crc_in, input logic [7:0] b);
        logic [31:0] c;
        c = crc_in ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

// ===== src/crv_in_if.sv =====
// Byte stream channel carrying record bytes into the validator.
interface crv_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

// ===== src/crv_out_if.sv =====
// Result channel carrying one status transaction per record.
interface crv_out_if;
    logic        valid;
    logic        ready;
    logic [3:0]  status;
    logic [7:0]  role_value;
    logic [7:0]  algorithm_value;
    logic [31:0] generation_count;
    logic [15:0] min_length_value;

    modport source (output valid, output status, output role_value, output algorithm_value,
                    output generation_count, output min_length_value, input ready);
    modport sink   (input valid, input status, input role_value, input algorithm_value,
                    input generation_count, input min_length_value, output ready);
endinterface

// ===== src/crv_judge.sv =====
// Priority checker that turns a captured record and the policy into a status code.
module crv_judge (
    input  crv_pkg::t_record i_rec,
    input  crv_pkg::t_policy i_pol,
    output crv_pkg::t_status o_status
);
    import crv_pkg::*;

    logic role_ok;
    logic len_ok;
    logic crc_ok;

    // Individual checks.
    assign role_ok = (i_rec.role == i_pol.role_a) || (i_rec.role == i_pol.role_b);
    assign len_ok  = (i_rec.min_len >= i_pol.min_len) && (i_rec.min_len <= i_pol.max_len);
    assign crc_ok  = (i_rec.stored_check == ~i_rec.crc);

    // First failing check wins.
    always_comb begin
        if (!i_rec.at_end) begin
            o_status = ST_LENGTH;
        end else if (i_rec.erased) begin
            o_status = ST_EMPTY;
        end else if (i_rec.magic_mismatch) begin
            o_status = ST_MAGIC;
        end else if (i_rec.version != i_pol.schema_version) begin
            o_status = ST_SCHEMA;
        end else if (!role_ok) begin
            o_status = ST_ROLE;
        end else if (i_rec.algorithm != i_pol.algorithm) begin
            o_status = ST_ALG;
        end else if (!len_ok) begin
            o_status = ST_POLICY;
        end else if (!crc_ok) begin
            o_status = ST_CRC;
        end else begin
            o_status = ST_OK;
        end
    end

endmodule

// ===== src/credential_record_validator_core.sv =====
// The final byte passes through the input register, and its result is then loaded into the result register.
// Throughput: one byte per cycle; the byte-wide CRC step and field capture fit in one stage.
// The input register and the result register decouple the two channels; bytes keep flowing
// while a result waits, and only a final byte stalls the input until that result is taken.
// Reset clears the record state, both pipeline registers and loads the policy defaults.
module credential_record_validator_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [crv_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [crv_pkg::CFG_DATA_W-1:0]  i_cfg_wdata,
    crv_in_if.sink                          i_rec,
    crv_out_if.source                       o_res
);
    import crv_pkg::*;

    // Configuration registers.
    logic [31:0] r_magic;
    t_policy     r_pol;

    // Input register.
    logic        r_s1_valid;
    logic [7:0]  r_s1_byte;
    logic        r_s1_last;

    // Record state.
    logic [POS_W-1:0] r_pos,     n_pos;
    logic [31:0]      r_crc,     n_crc;
    logic             r_erased,  n_erased;
    logic             r_mism,    n_mism;
    logic [15:0]      r_ver,     n_ver;
    logic [7:0]       r_role,    n_role;
    logic [7:0]       r_alg,     n_alg;
    logic [31:0]      r_gen,     n_gen;
    logic [15:0]      r_minlen,  n_minlen;
    logic [31:0]      r_stored,  n_stored;

    // Result register.
    logic        r_out_valid;
    t_status     r_out_status;
    logic [7:0]  r_out_role;
    logic [7:0]  r_out_alg;
    logic [31:0] r_out_gen;
    logic [15:0] r_out_minlen;

    logic    out_free;
    logic    s1_move;
    logic    s1_free;
    logic    out_load;
    t_record rec_view;
    t_status status;

    // Flow control between the two registers.
    assign out_free    = !r_out_valid || o_res.ready;
    assign s1_move     = r_s1_valid && (!r_s1_last || out_free);
    assign s1_free     = !r_s1_valid || s1_move;
    assign out_load    = s1_move && r_s1_last;
    assign i_rec.ready = s1_free;

    // Configuration writes; an index past the list is ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_magic              <= 32'd0;
            r_pol.schema_version <= 16'd1;
            r_pol.role_a         <= 8'd0;
            r_pol.role_b         <= 8'd1;
            r_pol.algorithm      <= 8'd0;
            r_pol.min_len        <= 16'd8;
            r_pol.max_len        <= 16'd64;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_MAGIC:   r_magic              <= i_cfg_wdata;
                CFG_SCHEMA:  r_pol.schema_version <= i_cfg_wdata[15:0];
                CFG_ROLE_A:  r_pol.role_a         <= i_cfg_wdata[7:0];
                CFG_ROLE_B:  r_pol.role_b         <= i_cfg_wdata[7:0];
                CFG_ALG:     r_pol.algorithm      <= i_cfg_wdata[7:0];
                CFG_MIN_LEN: r_pol.min_len        <= i_cfg_wdata[15:0];
                CFG_MAX_LEN: r_pol.max_len        <= i_cfg_wdata[15:0];
                default: begin
                end
            endcase
        end
    end

    // Input register: takes a new byte whenever the stage behind it moves on.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s1_free) begin
            r_s1_valid <= i_rec.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_free && i_rec.valid) begin
            r_s1_byte <= i_rec.data_byte;
            r_s1_last <= i_rec.last_byte;
        end
    end

    // Absorb one byte into the record state.
    always_comb begin
        n_pos    = (r_pos < POS_SAT) ? r_pos + 7'd1 : r_pos;
        n_erased = r_erased && (r_s1_byte == ERASED_BYTE);
        n_crc    = (r_pos < CRC_SPAN) ? crc_byte(r_crc, r_s1_byte) : r_crc;
        n_mism   = r_mism;
        n_ver    = r_ver;
        n_role   = r_role;
        n_alg    = r_alg;
        n_gen    = r_gen;
        n_minlen = r_minlen;
        n_stored = r_stored;
        if (r_pos < POS_MAGIC_END) begin
            if (r_magic[r_pos[1:0]*8 +: 8] != r_s1_byte) begin
                n_mism = 1'b1;
            end
        end else if (r_pos == POS_VER_LO) begin
            n_ver[7:0] = r_s1_byte;
        end else if (r_pos == POS_VER_HI) begin
            n_ver[15:8] = r_s1_byte;
        end else if (r_pos == POS_ROLE) begin
            n_role = r_s1_byte;
        end else if (r_pos == POS_ALG) begin
            n_alg = r_s1_byte;
        end else if (r_pos >= POS_GEN_LO && r_pos < POS_GEN_END) begin
            n_gen[r_pos[1:0]*8 +: 8] = r_s1_byte;
        end else if (r_pos == POS_MINLEN_LO) begin
            n_minlen[7:0] = r_s1_byte;
        end else if (r_pos == POS_MINLEN_HI) begin
            n_minlen[15:8] = r_s1_byte;
        end else if (r_pos >= CRC_SPAN && r_pos < RECORD_SIZE) begin
            n_stored[r_pos[1:0]*8 +: 8] = r_s1_byte;
        end
    end

    // Record state: advances per byte, cleared after the final byte is judged.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || out_load) begin
            r_pos    <= '0;
            r_crc    <= CRC_INIT;
            r_erased <= 1'b1;
            r_mism   <= 1'b0;
            r_ver    <= '0;
            r_role   <= '0;
            r_alg    <= '0;
            r_gen    <= '0;
            r_minlen <= '0;
            r_stored <= '0;
        end else if (s1_move) begin
            r_pos    <= n_pos;
            r_crc    <= n_crc;
            r_erased <= n_erased;
            r_mism   <= n_mism;
            r_ver    <= n_ver;
            r_role   <= n_role;
            r_alg    <= n_alg;
            r_gen    <= n_gen;
            r_minlen <= n_minlen;
            r_stored <= n_stored;
        end
    end

    // View of the record at its final byte; the CRC span ends before the stored check.
    always_comb begin
        rec_view.at_end         = (r_pos == RECORD_LAST);
        rec_view.erased         = n_erased;
        rec_view.magic_mismatch = r_mism;
        rec_view.version        = r_ver;
        rec_view.role           = r_role;
        rec_view.algorithm      = r_alg;
        rec_view.min_len        = r_minlen;
        rec_view.stored_check   = {r_s1_byte, r_stored[23:0]};
        rec_view.crc            = r_crc;
    end

    crv_judge u_judge (
        .i_rec    (rec_view),
        .i_pol    (r_pol),
        .o_status (status)
    );

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_status <= status;
            r_out_role   <= (status == ST_OK) ? r_role   : 8'd0;
            r_out_alg    <= (status == ST_OK) ? r_alg    : 8'd0;
            r_out_gen    <= (status == ST_OK) ? r_gen    : 32'd0;
            r_out_minlen <= (status == ST_OK) ? r_minlen : 16'd0;
        end
    end

    assign o_res.valid            = r_out_valid;
    assign o_res.status           = r_out_status;
    assign o_res.role_value       = r_out_role;
    assign o_res.algorithm_value  = r_out_alg;
    assign o_res.generation_count = r_out_gen;
    assign o_res.min_length_value = r_out_minlen;

    // A failed record never exposes captured fields.
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_status != ST_OK) |->
            (r_out_role == 8'd0 && r_out_alg == 8'd0 &&
             r_out_gen == 32'd0 && r_out_minlen == 16'd0))
        else $error("failed record carries captured fields");

    // Judging a record restarts the byte count for the next one.
    a_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |=> (r_pos == '0 && r_crc == CRC_INIT && r_erased))
        else $error("record state not cleared after final byte");

    // The byte count saturates and never runs past its ceiling.
    a_pos_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= POS_SAT)
        else $error("byte position beyond saturation");

    // A final byte never overwrites a result still waiting to be taken.
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_res.ready) |-> !out_load)
        else $error("result overwritten while stalled");

endmodule

// ===== dv/tb_credential_record_validator_core.sv =====
// Self-checking testbench for the credential record validator core.
module tb_credential_record_validator_core;
    import crv_pkg::*;

    // Length of the long result hold-off, and the overall time allowed for the run.
    localparam int HOLD_CYCLES = 300;
    localparam int RUN_LIMIT   = 4_000_000;

    // One status transaction as the block should produce it.
    typedef struct packed {
        t_status     status;
        logic [7:0]  role;
        logic [7:0]  algorithm;
        logic [31:0] generation;
        logic [15:0] min_len;
    } t_verdict;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_wdata;

    crv_in_if  rec_if ();
    crv_out_if res_if ();

    credential_record_validator_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .i_rec       (rec_if),
        .o_res       (res_if)
    );

    // Free-running clock, period 8.
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Local copy of the policy registers, starting from their reset values.
    logic [31:0] pol_magic  = 32'd0;
    logic [15:0] pol_schema = 16'd1;
    logic [7:0]  pol_role_a = 8'd0;
    logic [7:0]  pol_role_b = 8'd1;
    logic [7:0]  pol_alg    = 8'd0;
    logic [15:0] pol_min    = 16'd8;
    logic [15:0] pol_max    = 16'd64;

    // Predicted state of the record being received.
    logic [6:0]  rec_pos;
    logic [31:0] rec_crc;
    logic        rec_erased;
    logic        rec_magic_bad;
    logic [15:0] rec_version;
    logic [7:0]  rec_role;
    logic [7:0]  rec_alg;
    logic [31:0] rec_gen;
    logic [15:0] rec_minlen;
    logic [31:0] rec_stored;

    // Statuses still owed by the block, oldest first.
    t_verdict pending_verdicts[$];

    // Record under construction for the sender.
    logic [7:0] rec_buf [0:255];
    int         rec_len;

    // Sender and receiver behaviour.
    bit tx_gappy      = 1'b0;
    int burst_left    = 0;
    bit rx_steady     = 1'b1;
    bit rx_on         = 1'b1;
    int rx_run        = 0;
    int hold_requests = 0;
    int holds_done    = 0;
    int hold_left     = 0;

    // Run statistics.
    int failures         = 0;
    int bytes_sent       = 0;
    int records_sent     = 0;
    int policies_applied = 0;
    int verdicts_checked = 0;
    int status_count [0:15];

    // Reflected CRC-32, one input bit at a time.
    function automatic logic [31:0] crc32_step(input logic [31:0] c, input logic [7:0] b);
        logic [31:0] r;
        r = c;
        for (int i = 0; i < 8; i++) begin
            if (r[0] ^ b[i]) r = (r >> 1) ^ CRC_POLY;
            else r = r >> 1;
        end
        return r;
    endfunction

    function automatic void clear_record_state();
        rec_pos       = '0;
        rec_crc       = CRC_INIT;
        rec_erased    = 1'b1;
        rec_magic_bad = 1'b0;
        rec_version   = '0;
        rec_role      = '0;
        rec_alg       = '0;
        rec_gen       = '0;
        rec_minlen    = '0;
        rec_stored    = '0;
    endfunction

    // Fold one accepted byte into the predicted record and queue a status on the last byte.
    function automatic void absorb_byte(input logic [7:0] b, input logic is_last);
        logic [6:0] p;
        t_verdict   v;
        p = rec_pos;
        if (b != ERASED_BYTE) rec_erased = 1'b0;
        if (p < CRC_SPAN) rec_crc = crc32_step(rec_crc, b);
        if (p < 4) begin
            if (pol_magic[8*p +: 8] != b) rec_magic_bad = 1'b1;
        end else if (p < 6) begin
            rec_version[8*(p-4) +: 8] = b;
        end else if (p == 6) begin
            rec_role = b;
        end else if (p == 7) begin
            rec_alg = b;
        end else if (p < 12) begin
            rec_gen[8*(p-8) +: 8] = b;
        end else if (p < 14) begin
            rec_minlen[8*(p-12) +: 8] = b;
        end else if (p >= CRC_SPAN && p <= RECORD_LAST) begin
            rec_stored[8*(p-CRC_SPAN) +: 8] = b;
        end
        if (rec_pos < POS_SAT) rec_pos = rec_pos + 7'd1;
        if (is_last) begin
            v = '0;
            if (p != RECORD_LAST) v.status = ST_LENGTH;
            else if (rec_erased) v.status = ST_EMPTY;
            else if (rec_magic_bad) v.status = ST_MAGIC;
            else if (rec_version != pol_schema) v.status = ST_SCHEMA;
            else if (rec_role != pol_role_a && rec_role != pol_role_b) v.status = ST_ROLE;
            else if (rec_alg != pol_alg) v.status = ST_ALG;
            else if (rec_minlen < pol_min || rec_minlen > pol_max) v.status = ST_POLICY;
            else if (rec_stored != ~rec_crc) v.status = ST_CRC;
            else v.status = ST_OK;
            if (v.status == ST_OK) begin
                v.role       = rec_role;
                v.algorithm  = rec_alg;
                v.generation = rec_gen;
                v.min_len    = rec_minlen;
            end
            pending_verdicts.push_back(v);
            records_sent++;
            clear_record_state();
        end
    endfunction

    // Recompute the stored check over bytes 0 to 75 and fix the length at a full record.
    function automatic void seal_record();
        logic [31:0] c;
        c = CRC_INIT;
        for (int i = 0; i < CRC_SPAN; i++) c = crc32_step(c, rec_buf[i]);
        c = ~c;
        for (int k = 0; k < 4; k++) rec_buf[CRC_SPAN + k] = c[8*k +: 8];
        rec_len = int'(RECORD_SIZE);
    endfunction

    // Build a full record that matches the current magic and schema.
    function automatic void make_record(input logic [7:0] role, input logic [7:0] alg,
                                        input logic [31:0] gen, input logic [15:0] mlen);
        for (int k = 0; k < 4; k++) rec_buf[k] = pol_magic[8*k +: 8];
        rec_buf[4] = pol_schema[7:0];
        rec_buf[5] = pol_schema[15:8];
        rec_buf[6] = role;
        rec_buf[7] = alg;
        for (int k = 0; k < 4; k++) rec_buf[8 + k] = gen[8*k +: 8];
        rec_buf[12] = mlen[7:0];
        rec_buf[13] = mlen[15:8];
        for (int i = 14; i < CRC_SPAN; i++) rec_buf[i] = 8'($urandom);
        seal_record();
    endfunction

    // A record that the current policy accepts when its length bounds are in order, leaning towards those bounds.
    function automatic void good_record();
        logic [7:0]  role;
        logic [15:0] mlen;
        role = $urandom_range(0, 1) ? pol_role_a : pol_role_b;
        if (pol_min <= pol_max) begin
            mlen = 16'(pol_min + $urandom_range(0, pol_max - pol_min));
            if ($urandom_range(0, 3) == 0) mlen = $urandom_range(0, 1) ? pol_min : pol_max;
        end else begin
            mlen = 16'($urandom);
        end
        make_record(role, pol_alg, $urandom, mlen);
    endfunction

    function automatic void erase_record();
        for (int i = 0; i < RECORD_SIZE; i++) rec_buf[i] = ERASED_BYTE;
        rec_len = int'(RECORD_SIZE);
    endfunction

    // Offer one byte and wait for its transaction, with sender gaps between bursts.
    task automatic send_byte(input logic [7:0] b, input logic is_last);
        int gap;
        if (tx_gappy && burst_left == 0) begin
            rec_if.valid <= 1'b0;
            gap = $urandom_range(1, 10);
            repeat (gap) @(posedge i_clk);
            burst_left = $urandom_range(1, 24);
        end
        rec_if.valid     <= 1'b1;
        rec_if.data_byte <= b;
        rec_if.last_byte <= is_last;
        do @(posedge i_clk); while (!rec_if.ready);
        absorb_byte(b, is_last);
        bytes_sent++;
        if (burst_left > 0) burst_left--;
    endtask

    task automatic send_record();
        for (int i = 0; i < rec_len; i++) send_byte(rec_buf[i], i == rec_len - 1);
    endtask

    // Good record with two bytes disturbed, optionally resealed so only those fields are wrong.
    task automatic send_double(input int pos_a, input logic [7:0] flip_a,
                               input int pos_b, input logic [7:0] flip_b, input bit reseal);
        good_record();
        rec_buf[pos_a] ^= flip_a;
        rec_buf[pos_b] ^= flip_b;
        if (reseal) seal_record();
        send_record();
    endtask

    // Stop sending and wait for every owed status, then let the pipeline drain.
    task automatic settle();
        rec_if.valid <= 1'b0;
        while (pending_verdicts.size() != 0) @(posedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [31:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        case (idx)
            CFG_MAGIC:   pol_magic  = val;
            CFG_SCHEMA:  pol_schema = val[15:0];
            CFG_ROLE_A:  pol_role_a = val[7:0];
            CFG_ROLE_B:  pol_role_b = val[7:0];
            CFG_ALG:     pol_alg    = val[7:0];
            CFG_MIN_LEN: pol_min    = val[15:0];
            CFG_MAX_LEN: pol_max    = val[15:0];
            default: ;
        endcase
    endtask

    // Write all seven policy registers; only called while the block is idle.
    task automatic program_policy(input logic [31:0] magic, input logic [15:0] schema,
                                  input logic [7:0] role_a, input logic [7:0] role_b,
                                  input logic [7:0] alg, input logic [15:0] lo,
                                  input logic [15:0] hi);
        write_reg(CFG_MAGIC, magic);
        write_reg(CFG_SCHEMA, {16'd0, schema});
        write_reg(CFG_ROLE_A, {24'd0, role_a});
        write_reg(CFG_ROLE_B, {24'd0, role_b});
        write_reg(CFG_ALG, {24'd0, alg});
        write_reg(CFG_MIN_LEN, {16'd0, lo});
        write_reg(CFG_MAX_LEN, {16'd0, hi});
        i_cfg_we <= 1'b0;
        policies_applied++;
    endtask

    // A record checked against the policy that reset leaves behind.
    task automatic test_reset_policy();
        tx_gappy = 1'b0;
        rx_steady <= 1'b1;
        make_record(8'd1, 8'd0, 32'hFFFF_FFFF, 16'd64);
        send_record();
        settle();
    endtask

    // Each failing check in turn; every record up to the policy failure also breaks the next
    // check down, so the higher-ranked check has to win.
    task automatic test_status_priority();
        program_policy(32'hA5C3_5A3C, 16'h0102, 8'h11, 8'h22, 8'h33, 16'd12, 16'd300);
        tx_gappy = 1'b1;
        rx_steady <= 1'b0;
        erase_record();
        send_record();
        send_double($urandom_range(0, 3), 8'h01, 4, 8'h80, 1'b1);
        send_double(5, 8'h01, 6, 8'h40, 1'b1);
        send_double(6, 8'h40, 7, 8'h02, 1'b1);
        send_double(7, 8'h02, 13, 8'h80, 1'b1);
        send_double(13, 8'h80, 40, 8'h10, 1'b0);
        // A damaged payload byte and a damaged stored check.
        send_double(40, 8'h10, 77, 8'h01, 1'b0);
        // Length outranks an erased record.
        erase_record();
        rec_len = 20;
        send_record();
        settle();
    endtask

    // A record that runs past the saturation point, then a good one to show the state was cleared.
    task automatic test_length_handling();
        tx_gappy = 1'b0;
        good_record();
        for (int i = RECORD_SIZE; i < 83; i++) rec_buf[i] = 8'($urandom);
        rec_len = 83;
        send_record();
        good_record();
        send_record();
        settle();
    endtask

    // Bounds given the wrong way round reject every record.
    task automatic test_policy_extremes();
        program_policy(32'h1234_5678, 16'h0001, 8'h02, 8'h03, 8'h04, 16'd100, 16'd99);
        make_record(8'h03, 8'h04, $urandom, 16'd100);
        send_record();
        settle();
    endtask

    // The receiver holds off for a long stretch while short records keep coming.
    task automatic test_back_pressure();
        tx_gappy = 1'b0;
        rx_steady <= 1'b1;
        hold_requests <= hold_requests + 1;
        for (int n = 0; n < 25; n++) begin
            rec_len = $urandom_range(1, 2);
            for (int i = 0; i < rec_len; i++) rec_buf[i] = 8'($urandom);
            send_record();
        end
        settle();
    endtask

    // Result side: check each transaction, then choose ready for the next cycle.
    always @(posedge i_clk) begin : result_monitor
        t_verdict want;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            if (pending_verdicts.size() == 0) begin
                $error("Unexpected result transaction with status %0d", res_if.status);
                failures++;
            end else begin
                want = pending_verdicts.pop_front();
                verdicts_checked++;
                status_count[res_if.status]++;
                if (res_if.status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, res_if.status);
                    failures++;
                end
                if (res_if.role_value !== want.role) begin
                    $error("role_value: expected %0h, got %0h", want.role, res_if.role_value);
                    failures++;
                end
                if (res_if.algorithm_value !== want.algorithm) begin
                    $error("algorithm_value: expected %0h, got %0h",
                           want.algorithm, res_if.algorithm_value);
                    failures++;
                end
                if (res_if.generation_count !== want.generation) begin
                    $error("generation_count: expected %0h, got %0h",
                           want.generation, res_if.generation_count);
                    failures++;
                end
                if (res_if.min_length_value !== want.min_len) begin
                    $error("min_length_value: expected %0d, got %0d",
                           want.min_len, res_if.min_length_value);
                    failures++;
                end
            end
        end
        if (hold_left > 0) begin
            hold_left--;
            res_if.ready <= 1'b0;
        end else if (holds_done != hold_requests) begin
            holds_done++;
            hold_left = HOLD_CYCLES;
            res_if.ready <= 1'b0;
        end else if (rx_steady) begin
            res_if.ready <= 1'b1;
        end else begin
            // Alternate runs of ready and stall with random lengths.
            if (rx_run == 0) begin
                rx_on  = !rx_on;
                rx_run = rx_on ? $urandom_range(1, 12) : $urandom_range(1, 5);
            end
            rx_run--;
            res_if.ready <= rx_on;
        end
    end

    // Watchdog for a run that never finishes.
    initial begin
        #RUN_LIMIT;
        $display("Some tests failed");
        $finish;
    end

    // Main sequence.
    initial begin
        for (int s = 0; s < 16; s++) status_count[s] = 0;
        clear_record_state();
        rec_if.valid     <= 1'b0;
        rec_if.data_byte <= 8'd0;
        rec_if.last_byte <= 1'b0;
        i_cfg_we         <= 1'b0;
        i_cfg_index      <= CFG_MAGIC;
        i_cfg_wdata      <= '0;
        i_rst_n          <= 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_policy();
        test_status_priority();
        test_length_handling();
        test_policy_extremes();
        test_back_pressure();
        settle();

        $display("Run covered %0d record bytes in %0d records over %0d register settings,",
                 bytes_sent, records_sent, policies_applied);
        $display("%0d results checked: ok %0d, empty %0d, length %0d, magic %0d, schema %0d, %s",
                 verdicts_checked, status_count[ST_OK], status_count[ST_EMPTY],
                 status_count[ST_LENGTH], status_count[ST_MAGIC], status_count[ST_SCHEMA],
                 $sformatf("role %0d, algorithm %0d, policy %0d, crc %0d.",
                           status_count[ST_ROLE], status_count[ST_ALG],
                           status_count[ST_POLICY], status_count[ST_CRC]));
        if (failures == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
